[design/icm_pkg.sv]
// Shared types and constants for the iteration convergence monitor.
`timescale 1ns / 1ps

package icm_pkg;

    // Input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TINY      = 2'd2;

    // Configuration reset values
    localparam logic [31:0] TOLERANCE_RESET = 32'd66;
    localparam logic        TRACK_RESET     = 1'b1;
    localparam logic [31:0] TINY_RESET      = 32'd0;

    // Input item
    typedef struct packed {
        logic               command;
        logic signed [31:0] sample_value;
    } t_in;

    // Result item
    typedef struct packed {
        logic               converged;
        logic [31:0]        convergence_rate;
        logic [31:0]        last_change;
        logic [2:0]         window_fill;
        logic signed [31:0] prior_value;
    } t_out;

    // Window control from the sequencer
    typedef struct packed {
        logic push;
        logic clear;
    } t_win_cmd;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHG,
        S_RDA,
        S_LDA,
        S_LDB,
        S_DIV,
        S_NEXT,
        S_MEAN,
        S_MDIV,
        S_DONE
    } t_state;

endpackage

[design/icm_div.sv]
// Bit-serial restoring divider with a 32-bit saturated quotient.
`timescale 1ns / 1ps

module icm_div #(
    parameter int DW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    output logic          o_done,
    output logic [31:0]   o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [31:0]   r_div;
    logic [DW-1:0] r_q;

    logic [32:0]   w_rem_sh;
    logic [33:0]   w_diff;
    logic          w_ge;

    // One trial subtract per cycle
    assign w_rem_sh = {r_rem, r_q[DW-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_div};
    assign w_ge     = ~w_diff[33];

    // Control: count quotient bits, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_rem_sh[31:0];
            r_q   <= {r_q[DW-2:0], w_ge};
        end
    end

    // Saturate quotient to 32 bits
    assign o_done = r_done;
    assign o_quot = (|r_q[DW-1:32]) ? 32'hFFFF_FFFF : r_q[31:0];

    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with zero count");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

endmodule

[design/icm_win.sv]
// Circular change window with fill count and one registered read port.
`timescale 1ns / 1ps

module icm_win #(
    parameter int WINDOW = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  icm_pkg::t_win_cmd             i_cmd,
    input  logic [31:0]                   i_push_data,
    input  logic [$clog2(WINDOW)-1:0]     i_rd_idx,
    output logic [31:0]                   o_rd_data,
    output logic [$clog2(WINDOW+1)-1:0]   o_fill
);

    localparam int IW = $clog2(WINDOW);
    localparam int FW = $clog2(WINDOW + 1);
    localparam logic [IW:0]   WIN_X  = (IW + 1)'(WINDOW);
    localparam logic [FW-1:0] WIN_F  = FW'(WINDOW);
    localparam logic [IW-1:0] LAST_I = IW'(WINDOW - 1);

    logic [31:0]   r_mem [WINDOW];
    logic [31:0]   r_rd_data;
    logic [IW-1:0] r_head;
    logic [FW-1:0] r_fill;

    logic          w_full;
    logic [IW:0]   w_wr_sum;
    logic [IW:0]   w_rd_sum;
    logic [IW-1:0] w_wr_addr;
    logic [IW-1:0] w_rd_addr;
    logic [IW-1:0] w_head_inc;

    // Map logical positions (oldest first) onto physical entries
    assign w_full     = (r_fill == WIN_F);
    assign w_wr_sum   = {1'b0, r_head} + {1'b0, r_fill[IW-1:0]};
    assign w_rd_sum   = {1'b0, r_head} + {1'b0, i_rd_idx};
    assign w_wr_addr  = w_full ? r_head
                      : ((w_wr_sum >= WIN_X) ? IW'(w_wr_sum - WIN_X) : w_wr_sum[IW-1:0]);
    assign w_rd_addr  = (w_rd_sum >= WIN_X) ? IW'(w_rd_sum - WIN_X) : w_rd_sum[IW-1:0];
    assign w_head_inc = (r_head == LAST_I) ? '0 : r_head + IW'(1);

    // Write pushed change, register the read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.clear) begin
            r_mem[w_wr_addr] <= i_push_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Track oldest entry and fill; drop the oldest when full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_cmd.clear) begin
            r_fill <= '0;
        end else if (i_cmd.push) begin
            if (w_full) begin
                r_head <= w_head_inc;
            end else begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_fill    = r_fill;

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= WIN_F)
        else $error("window fill beyond depth");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_fill == '0))
        else $error("window not empty after clear");

endmodule

[design/iteration_convergence_monitor.sv]
// Top level: sequencer, value registers, configuration and result register.
`timescale 1ns / 1ps

// Usage:
// Input channel (i_in_valid / o_in_stall, payload i_in_data) takes one command:
// a new iterate value, or a clear of the change history. Each command yields
// exactly one result on the output channel (o_out_valid / i_out_stall,
// payload o_out_data). Configuration goes over i_cfg_valid / o_cfg_ready with
// i_cfg_index and i_cfg_data; ready is always high and writes land at once.
// One item is processed at a time. With fewer than two changes in the window
// no ratio is formed and the rate is zero; a ratio whose denominator is at or
// below tiny_difference skips the division. The ratios and the final mean
// share the bit-serial divider, which yields one quotient bit per cycle and
// whose width is DW = max(32+FRAC_BITS, 32+clog2(WINDOW)), 48 by default.
// A new item is taken the cycle after the previous one has reached the result
// register, even while the receiver still stalls that result.
// Reset (synchronous, active low) zeroes the values and the fill count and
// restores the register defaults; no clearing pass is needed.
module iteration_convergence_monitor #(
    parameter int WINDOW    = 5,
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  icm_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output icm_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [icm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    localparam int IW = $clog2(WINDOW);
    localparam int FW = $clog2(WINDOW + 1);
    localparam int SW = 32 + $clog2(WINDOW);
    localparam int RW = 32 + FRAC_BITS;
    localparam int DW = (RW > SW) ? RW : SW;

    // Configuration registers
    logic [31:0] r_tolerance;
    logic        r_track;
    logic [31:0] r_tiny;

    // Item state
    icm_pkg::t_state    r_state;
    icm_pkg::t_state    n_state;
    logic               r_cmd;
    logic signed [31:0] r_present;
    logic signed [31:0] r_older;
    logic [31:0]        r_change;
    logic [31:0]        r_a;
    logic [31:0]        r_b;
    logic [IW-1:0]      r_k;
    logic [SW-1:0]      r_sum;
    logic [31:0]        r_rate;
    icm_pkg::t_out      r_out;
    logic               r_out_valid;

    logic               w_in_acc;
    logic               w_cfg_clear;
    logic [32:0]        w_diff_po;
    logic [32:0]        w_diff_op;
    logic [31:0]        w_change;
    logic               w_last;
    logic               w_load;
    icm_pkg::t_win_cmd  w_win_cmd;
    logic [IW-1:0]      w_rd_idx;
    logic [31:0]        w_rd_data;
    logic [FW-1:0]      w_fill;
    logic               w_div_start;
    logic [DW-1:0]      w_dividend;
    logic [31:0]        w_divisor;
    logic               w_div_done;
    logic [31:0]        w_quot;

    assign o_in_stall  = (r_state != icm_pkg::S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_clear = i_cfg_valid && (i_cfg_index == icm_pkg::CFG_TRACK) && !i_cfg_data[0];

    // Absolute change: both differences in parallel, pick by sign
    assign w_diff_po = {r_present[31], r_present} - {r_older[31], r_older};
    assign w_diff_op = {r_older[31], r_older} - {r_present[31], r_present};
    assign w_change  = w_diff_po[32] ? w_diff_op[31:0] : w_diff_po[31:0];

    assign w_last = (FW'(r_k) == (w_fill - FW'(1)));

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= icm_pkg::TOLERANCE_RESET;
            r_track     <= icm_pkg::TRACK_RESET;
            r_tiny      <= icm_pkg::TINY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                icm_pkg::CFG_TOLERANCE: r_tolerance <= i_cfg_data;
                icm_pkg::CFG_TRACK:     r_track     <= i_cfg_data[0];
                icm_pkg::CFG_TINY:      r_tiny      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            icm_pkg::S_IDLE: if (w_in_acc) n_state = icm_pkg::S_CHG;
            icm_pkg::S_CHG:  n_state = icm_pkg::S_RDA;
            icm_pkg::S_RDA: begin
                n_state = (w_fill < FW'(2)) ? icm_pkg::S_DONE : icm_pkg::S_LDA;
            end
            icm_pkg::S_LDA:  n_state = icm_pkg::S_LDB;
            icm_pkg::S_LDB: begin
                n_state = (r_a > r_tiny) ? icm_pkg::S_DIV : icm_pkg::S_NEXT;
            end
            icm_pkg::S_DIV:  if (w_div_done) n_state = icm_pkg::S_NEXT;
            icm_pkg::S_NEXT: n_state = w_last ? icm_pkg::S_MEAN : icm_pkg::S_LDB;
            icm_pkg::S_MEAN: n_state = icm_pkg::S_MDIV;
            icm_pkg::S_MDIV: if (w_div_done) n_state = icm_pkg::S_DONE;
            icm_pkg::S_DONE: if (!r_out_valid || !i_out_stall) n_state = icm_pkg::S_IDLE;
            default:         n_state = icm_pkg::S_IDLE;
        endcase
    end

    // State outputs: window control, read index, divider start, result load
    always_comb begin
        w_win_cmd.push  = 1'b0;
        w_win_cmd.clear = w_cfg_clear;
        w_rd_idx        = '0;
        w_div_start     = 1'b0;
        w_load          = 1'b0;
        unique case (r_state)
            icm_pkg::S_CHG: begin
                w_win_cmd.push  = (r_cmd == icm_pkg::CMD_SAMPLE) && r_track;
                w_win_cmd.clear = w_cfg_clear || (r_cmd == icm_pkg::CMD_CLEAR);
            end
            icm_pkg::S_LDA:  w_rd_idx = IW'(1);
            icm_pkg::S_LDB:  w_div_start = (r_a > r_tiny);
            icm_pkg::S_NEXT: w_rd_idx = r_k + IW'(1);
            icm_pkg::S_MEAN: w_div_start = 1'b1;
            icm_pkg::S_DONE: w_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    // Divider operands: ratio term or final mean
    assign w_dividend = (r_state == icm_pkg::S_MEAN) ? DW'(r_sum)
                                                     : (DW'(w_rd_data) << FRAC_BITS);
    assign w_divisor  = (r_state == icm_pkg::S_MEAN) ? 32'(w_fill - FW'(1)) : r_a;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= icm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Iterate values: shift in on a new sample, hold on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_older   <= '0;
        end else if (w_in_acc && (i_in_data.command == icm_pkg::CMD_SAMPLE)) begin
            r_older   <= r_present;
            r_present <= i_in_data.sample_value;
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd <= i_in_data.command;
        end
        unique case (r_state)
            icm_pkg::S_CHG: begin
                r_change <= w_change;
                r_sum    <= '0;
                r_rate   <= '0;
            end
            icm_pkg::S_LDA: begin
                r_a <= w_rd_data;
                r_k <= IW'(1);
            end
            icm_pkg::S_LDB: r_b <= w_rd_data;
            icm_pkg::S_DIV: if (w_div_done) r_sum <= r_sum + SW'(w_quot);
            icm_pkg::S_NEXT: begin
                r_a <= r_b;
                if (!w_last) r_k <= r_k + IW'(1);
            end
            icm_pkg::S_MDIV: if (w_div_done) r_rate <= w_quot;
            default: ;
        endcase
    end

    // Result register: load when free or being taken, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.converged        <= (r_change < r_tolerance);
            r_out.convergence_rate <= r_rate;
            r_out.last_change      <= r_change;
            r_out.window_fill      <= 3'(w_fill);
            r_out.prior_value      <= r_older;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    icm_win #(
        .WINDOW (WINDOW)
    ) u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_win_cmd),
        .i_push_data (w_change),
        .i_rd_idx    (w_rd_idx),
        .o_rd_data   (w_rd_data),
        .o_fill      (w_fill)
    );

    icm_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    a_acc_to_chg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == icm_pkg::S_CHG))
        else $error("transfer not followed by change step");

    a_pair_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == icm_pkg::S_LDB) |-> ((r_k != '0) && (FW'(r_k) < w_fill)))
        else $error("ratio pair index outside window");

endmodule

[tb/icm_checker.sv]
// Checker for the iteration convergence monitor: watches the channels and predicts results.
`timescale 1ns / 1ps

module icm_checker #(
    parameter int WINDOW    = 5,
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  icm_pkg::t_in                    i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  icm_pkg::t_out                   i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [icm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);

    // Register shadow
    logic [31:0]        tolerance;
    logic               track_on;
    logic [31:0]        tiny_diff;

    // Iterate values and the window of recent changes
    logic signed [31:0] cur_value;
    logic signed [31:0] prev_value;
    logic [31:0]        changes [WINDOW];
    int                 fill;

    icm_pkg::t_out      results_due [$];

    function automatic logic [31:0] value_delta();
        longint d;
        d = longint'(cur_value) - longint'(prev_value);
        if (d < 0)
            d = -d;
        return d[31:0];
    endfunction

    // Mean of the ratios of consecutive changes, oldest first
    function automatic logic [31:0] mean_change_ratio();
        logic [63:0] total;
        logic [63:0] term;
        if (fill < 2)
            return 32'd0;
        total = 64'd0;
        for (int k = 0; k + 1 < fill; k++) begin
            if (changes[k] > tiny_diff) begin
                term = ({32'd0, changes[k+1]} << FRAC_BITS) / {32'd0, changes[k]};
                if (term > 64'hFFFF_FFFF)
                    term = 64'hFFFF_FFFF;
                total += term;
            end
        end
        term = total / 64'(fill - 1);
        if (term > 64'hFFFF_FFFF)
            term = 64'hFFFF_FFFF;
        return term[31:0];
    endfunction

    // Advance the value history by one item and form its result
    function automatic icm_pkg::t_out track_iterate(icm_pkg::t_in item);
        icm_pkg::t_out res;
        logic [31:0]   delta;
        if (item.command == icm_pkg::CMD_CLEAR) begin
            fill = 0;
        end else begin
            prev_value = cur_value;
            cur_value  = item.sample_value;
            if (track_on) begin
                delta = value_delta();
                if (fill >= WINDOW) begin
                    for (int k = 0; k < WINDOW - 1; k++)
                        changes[k] = changes[k+1];
                    changes[WINDOW-1] = delta;
                end else begin
                    changes[fill] = delta;
                    fill++;
                end
            end
        end
        delta                = value_delta();
        res.converged        = (delta < tolerance);
        res.convergence_rate = mean_change_ratio();
        res.last_change      = delta;
        res.window_fill      = fill[2:0];
        res.prior_value      = prev_value;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        icm_pkg::t_out want;
        if (!i_rst_n) begin
            tolerance  = icm_pkg::TOLERANCE_RESET;
            track_on   = icm_pkg::TRACK_RESET;
            tiny_diff  = icm_pkg::TINY_RESET;
            cur_value  = '0;
            prev_value = '0;
            fill       = 0;
            results_due.delete();
        end else begin
            // Register writes must land while the block is idle; not enforced here
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    icm_pkg::CFG_TOLERANCE: tolerance = i_cfg_data;
                    icm_pkg::CFG_TRACK: begin
                        track_on = i_cfg_data[0];
                        if (!track_on)
                            fill = 0;
                    end
                    icm_pkg::CFG_TINY:      tiny_diff = i_cfg_data;
                    default: ;
                endcase
            end

            // Compare the result transfer against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             i_out_data);
                    o_errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("converged", 32'(want.converged), 32'(i_out_data.converged));
                    check_field("convergence_rate", want.convergence_rate,
                                i_out_data.convergence_rate);
                    check_field("last_change", want.last_change, i_out_data.last_change);
                    check_field("window_fill", 32'(want.window_fill),
                                32'(i_out_data.window_fill));
                    check_field("prior_value", want.prior_value, i_out_data.prior_value);
                end
            end

            // Predict the result of each input transfer
            if (i_in_valid && !i_in_stall)
                results_due.insert(results_due.size(), track_iterate(i_in_data));
        end
        o_pending = results_due.size();
    end

endmodule

[tb/tb_iteration_convergence_monitor.sv]
// Testbench top for the iteration convergence monitor: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_iteration_convergence_monitor;

    localparam int                            WINDOW      = 5;
    localparam int                            FRAC_BITS   = 16;
    localparam logic [icm_pkg::CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam int                            RAND_PHASES = 8;
    localparam int                            PHASE_ITEMS = 125;
    localparam int                            HOLD_CYCLES = 2000;
    localparam int                            DRAIN_LIMIT = 200000;
    localparam int                            SETTLE      = 300;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    icm_pkg::t_in                    i_in_data;
    logic                            o_out_valid;
    logic                            i_out_stall;
    icm_pkg::t_out                   o_out_data;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [icm_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [31:0]                     i_cfg_data;

    int                    mismatches;
    int                    results_owed;
    int                    idle_pct;
    int                    holdoff_requests;

    iteration_convergence_monitor #(
        .WINDOW    (WINDOW),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    icm_checker #(
        .WINDOW    (WINDOW),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (mismatches),
        .o_pending   (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung run
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic icm_pkg::t_in make_item(logic cmd, logic [31:0] value);
        icm_pkg::t_in item;
        item.command      = cmd;
        item.sample_value = value;
        return item;
    endfunction

    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(icm_pkg::t_in item);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = item;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_sample(logic [31:0] value);
        send_item(make_item(icm_pkg::CMD_SAMPLE, value));
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (results_owed != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [icm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_level(bit rare_top);
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return rare_top ? $urandom_range(0, 32'h100) : 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h40000);
            default: return rare_top ? $urandom_range(0, 32'h0100_0000) : $urandom;
        endcase
    endfunction

    // Result side: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        int holds_done;
        hold_left   = 0;
        holds_done  = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_done < holdoff_requests) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < idle_pct);
            end
        end
    end

    initial begin
        logic signed [31:0] last_value;
        logic [31:0]        walk_step;
        logic [31:0]        value;
        int                 drain;
        idle_pct         = 35;
        holdoff_requests = 0;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_in_data        = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = icm_pkg::CFG_TOLERANCE;
        i_cfg_data       = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default registers: field extremes, full-scale changes, ratio saturation
        send_sample(32'h0000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0001);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_item(make_item(icm_pkg::CMD_CLEAR, 32'h1234_5678));
        send_sample(32'd65);
        send_sample(32'd0);

        // Tracking off empties the window; zero tolerance never converges
        wait_idle();
        write_reg(icm_pkg::CFG_TOLERANCE, 32'd0);
        write_reg(icm_pkg::CFG_TINY, 32'hFFFF_FFFF);
        write_reg(icm_pkg::CFG_TRACK, 32'd0);
        send_sample(32'h0001_0000);
        send_sample(32'h0001_0000);
        send_item(make_item(icm_pkg::CMD_CLEAR, 32'hEDCB_A987));

        // Wide tolerance, small denominators skipped, spare index ignored
        wait_idle();
        write_reg(icm_pkg::CFG_TRACK, 32'd1);
        write_reg(icm_pkg::CFG_TOLERANCE, 32'hFFFF_FFFF);
        write_reg(icm_pkg::CFG_TINY, 32'h0001_0000);
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0010_0000);
        send_sample(32'h0010_8000);
        send_sample(32'h0010_C000);
        send_sample(32'h0010_E000);
        send_sample(32'h0010_F000);

        wait_idle();
        write_reg(icm_pkg::CFG_TOLERANCE, icm_pkg::TOLERANCE_RESET);
        write_reg(icm_pkg::CFG_TINY, icm_pkg::TINY_RESET);

        // Random phases: mostly converging walks, some noise, extremes and clears
        last_value = 32'h0010_F000;
        walk_step  = 32'h0001_0000;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph != 0) begin
                wait_idle();
                write_reg(icm_pkg::CFG_TOLERANCE, pick_level(1'b0));
                write_reg(icm_pkg::CFG_TINY, pick_level(1'b1));
                write_reg(icm_pkg::CFG_TRACK, ($urandom_range(0, 9) < 8) ? 32'd1 : 32'd0);
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_SPARE, $urandom);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long stretch without idling, with a receiver hold-off inside it
                if (ph == 3 && n == 0)
                    idle_pct = 0;
                if (ph == 4 && n == 0)
                    idle_pct = 35;
                if ((ph == 1 || ph == 3) && n == 10)
                    holdoff_requests++;
                if ($urandom_range(0, 99) < 5) begin
                    send_item(make_item(icm_pkg::CMD_CLEAR, $urandom));
                end else begin
                    case ($urandom_range(0, 19))
                        0, 1, 2: value = $urandom;
                        3: value = 32'h7FFF_FFFF;
                        4: value = 32'h8000_0000;
                        default: begin
                            walk_step = 32'((64'(walk_step) * $urandom_range(1, 15)) / 16);
                            if (walk_step < 2)
                                walk_step = $urandom_range(1, 32'h00FF_FFFF);
                            value = $urandom_range(0, 1) ? last_value + walk_step
                                                         : last_value - walk_step;
                        end
                    endcase
                    last_value = value;
                    send_sample(value);
                end
            end
        end

        // Drain and settle, then give the verdict
        i_in_valid = 1'b0;
        drain = 0;
        while (results_owed != 0 && drain < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0 && results_owed == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[iteration_convergence_monitor.f]
design/icm_pkg.sv
design/icm_div.sv
design/icm_win.sv
design/iteration_convergence_monitor.sv
tb/icm_checker.sv
tb/tb_iteration_convergence_monitor.sv
